### hw/rtl/motor_position_drive_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor position drive
// Shared forms for concurrent checks on the block's own clock and reset.
// ----------------------------------------------------------------------------
`ifndef MOTOR_POSITION_DRIVE_ASSERT_SVH
`define MOTOR_POSITION_DRIVE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/mpd_pkg.sv
// ----------------------------------------------------------------------------
// Motor position drive package
// Register indexes, codes, constants and shared types of the drive block.
// ----------------------------------------------------------------------------
package mpd_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FB_CLOSED  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FB_OPEN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ON     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FB_PRESENT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_CAP    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY   = 3'd7;

	// Item function codes.
	localparam logic [1:0] FUNC_FAST = 2'd0;
	localparam logic [1:0] FUNC_SLOW = 2'd1;
	localparam logic [1:0] FUNC_CMD  = 2'd2;

	// Pin drive source codes.
	localparam logic [1:0] LVL_INACT = 2'd0;
	localparam logic [1:0] LVL_ACT   = 2'd1;
	localparam logic [1:0] LVL_DUTY  = 2'd2;

	// Fixed values.
	localparam logic [10:0] FB_FULL         = 11'd1024;
	localparam logic [30:0] DEFAULT_ON_TIME = 31'd10000;
	localparam logic [7:0]  POS_MID         = 8'd127;
	localparam logic [7:0]  DUTY_FULL       = 8'd255;
	localparam int          PERMIT_W        = 4;
	localparam logic [PERMIT_W-1:0] PERMIT_MAX = 4'd15;

	// floor(51*e/5) for e up to 255 equals (e*51*13108) >> 16.
	localparam logic [19:0] F25_MULT  = 20'd668508;
	localparam int          F25_SHIFT = 16;

	// Divider: eight quotient bits, two per cycle.
	localparam int DIV_BITS_PER_CYCLE = 2;
	localparam int DIV_CNT_W          = 2;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = 2'd3;

	// Configuration register file contents.
	typedef struct packed {
		logic [10:0] fb_closed;
		logic [10:0] fb_open;
		logic [30:0] max_on_time;
		logic        fb_present;
		logic        invert;
		logic [1:0]  pwm_cap;
		logic [7:0]  tolerance;
		logic [7:0]  min_duty;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic prep;
		logic div_step;
		logic eval;
		logic mul;
		logic fin;
		logic push;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic poll_go;
	} dp_status_t;

	// One result item.
	typedef struct packed {
		logic       drive_changed;
		logic [7:0] up_drive;
		logic [7:0] down_drive;
		logic       target_reached;
		logic       timed_out;
		logic       accepted;
	} result_t;

endpackage

### hw/rtl/mpd_ctrl.sv
// ----------------------------------------------------------------------------
// Motor position drive controller
// Sequences motion polls through setup, division, evaluation and delivery.
// ----------------------------------------------------------------------------
module mpd_ctrl
	import mpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_EVAL = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_PUSH = 3'd6;

	logic [2:0]           state_q;
	logic [2:0]           state_d;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic                 slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	// Commands decoded from the current state.
	always_comb begin
		cmd          = '0;
		cmd.accept   = in_ready && in_valid;
		cmd.prep     = (state_q == ST_PREP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.eval     = (state_q == ST_EVAL);
		cmd.mul      = (state_q == ST_MUL);
		cmd.fin      = (state_q == ST_FIN);
		cmd.push     = (state_q == ST_PUSH) && slot_free;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = status.poll_go ? ST_PREP : ST_PUSH;
				end
			end
			ST_PREP: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: state_d = ST_MUL;
			ST_MUL:  state_d = ST_FIN;
			ST_FIN:  state_d = ST_PUSH;
			ST_PUSH: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State, iteration count and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`include "motor_position_drive_assert.svh"

	// A result enters the output register only when that register is free.
	`MPD_ASSERT_SAME(a_push_slot_free, cmd.push, slot_free, "push into a full output register")

	// A pushed result is offered in the next cycle.
	`MPD_ASSERT_NEXT(a_push_valid, cmd.push, out_valid_q, "pushed result not offered")

	// An item with no motion work goes straight to delivery.
	`MPD_ASSERT_NEXT(a_short_path, in_valid && in_ready && !status.poll_go, state_q == ST_PUSH,
		"short item did not go to delivery")

	// The divider hands over to evaluation after its last step.
	`MPD_ASSERT_NEXT(a_div_exit, state_q == ST_DIV && cnt_q == DIV_LAST, state_q == ST_EVAL,
		"divider did not finish on its last cycle")

endmodule

### hw/rtl/mpd_datapath.sv
// ----------------------------------------------------------------------------
// Motor position drive datapath
// Move state, feedback scaling divider, error evaluation and pin drive levels.
// ----------------------------------------------------------------------------
module mpd_datapath
	import mpd_pkg::*;
#(
	parameter int unsigned MOVE_QUOTA = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic [1:0]  func,
	input  logic [7:0]  target_value,
	input  logic        off_request,
	input  logic [9:0]  feedback_sample,
	input  logic [31:0] now_ms,
	input  ctrl_cmd_t   cmd,
	output dp_status_t  status,
	output result_t     result
);

	// Move state.
	logic                move_req_q;
	logic                in_prog_q;
	logic [31:0]         start_q;
	logic [PERMIT_W-1:0] permit_q;
	logic [7:0]          target_q;
	logic                off_q;

	// Item payload.
	logic [9:0]  sample_q;
	logic [31:0] now_q;

	// Divider and evaluation registers.
	logic [17:0] rem_q;
	logic [17:0] dsh_q;
	logic [7:0]  quo_q;
	logic        neg_q;
	logic        sat_q;
	logic        timeout_q;
	logic [7:0]  e_q;
	logic        stop_q;
	logic [1:0]  up_code_q;
	logic [1:0]  dn_code_q;
	logic        sel51_q;
	logic        rev_q;
	logic        lo_zero_q;
	logic [11:0] f25_q;

	result_t res_q;
	result_t out_q;

	// Combinational values.
	logic [10:0]        cl_eff;
	logic [10:0]        op_eff;
	logic signed [11:0] s_diff;
	logic signed [11:0] d_diff;
	logic [10:0]        s_abs;
	logic [10:0]        d_abs;
	logic [18:0]        n_full;
	logic [31:0]        elapsed;
	logic [30:0]        lim;
	logic               timeout_d;
	logic [17:0]        rem_d;
	logic [17:0]        dsh_d;
	logic [7:0]         quo_d;
	logic [7:0]         pos;
	logic [7:0]         tgt;
	logic signed [9:0]  dif;
	logic signed [9:0]  tol_s;
	logic signed [9:0]  magn;
	logic               below;
	logic               above;
	logic [1:0]         up_code_d;
	logic [1:0]         dn_code_d;
	logic               sel51_d;
	logic               rev_d;
	logic               lo_zero_d;
	logic [27:0]        f25_prod;
	logic [10:0]        five_e;
	logic [11:0]        base;
	logic signed [12:0] vsig;
	logic [7:0]         lo;
	logic [7:0]         duty;
	logic [7:0]         act;
	logic [7:0]         inact;
	logic [7:0]         up_lvl;
	logic [7:0]         dn_lvl;

	function automatic logic [31:0] nonzero_time(input logic [31:0] t);
		nonzero_time = (t == 32'd0) ? 32'd1 : t;
	endfunction

	assign result = out_q;

	// A fast poll moves only with a request and a move in progress or a permit.
	assign status.poll_go = (func == FUNC_FAST) && move_req_q &&
		(in_prog_q || (permit_q != '0));

	// Effective feedback endpoints and the signed terms of the linear map.
	always_comb begin
		op_eff  = (cfg.fb_open > FB_FULL) ? 11'd0 : cfg.fb_open;
		cl_eff  = (cfg.fb_closed > FB_FULL) ? FB_FULL : cfg.fb_closed;
		s_diff  = $signed({2'b00, sample_q}) - $signed({1'b0, cl_eff});
		d_diff  = $signed({1'b0, op_eff}) - $signed({1'b0, cl_eff});
		s_abs   = s_diff[11] ? 11'(-s_diff) : s_diff[10:0];
		d_abs   = d_diff[11] ? 11'(-d_diff) : d_diff[10:0];
		n_full  = {s_abs, 8'b0} - {8'b0, s_abs};
	end

	// On-time limit check against the running timer.
	always_comb begin
		elapsed   = now_q - start_q;
		lim       = (cfg.max_on_time == '0) ? DEFAULT_ON_TIME : cfg.max_on_time;
		timeout_d = (start_q != 32'd0) && (elapsed >= {1'b0, lim});
	end

	// Two restoring division steps per cycle.
	always_comb begin
		rem_d = rem_q;
		dsh_d = dsh_q;
		quo_d = quo_q;
		for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
			if (rem_d >= dsh_d) begin
				rem_d = rem_d - dsh_d;
				quo_d = {quo_d[6:0], 1'b1};
			end else begin
				quo_d = {quo_d[6:0], 1'b0};
			end
			dsh_d = dsh_d >> 1;
		end
	end

	// Position, signed error and the pin drive plan.
	always_comb begin
		if (!cfg.fb_present) begin
			pos = POS_MID;
		end else if (op_eff == cl_eff) begin
			pos = 8'd0;
		end else if (neg_q) begin
			pos = 8'd0;
		end else if (sat_q) begin
			pos = DUTY_FULL;
		end else begin
			pos = quo_q;
		end
		tgt   = off_q ? 8'd0 : target_q;
		dif   = timeout_q ? 10'sd0 : ($signed({2'b00, tgt}) - $signed({2'b00, pos}));
		tol_s = $signed({2'b00, cfg.tolerance});
		below = dif < -tol_s;
		above = dif > tol_s;
		magn  = below ? -dif : dif;

		up_code_d = LVL_INACT;
		dn_code_d = LVL_INACT;
		sel51_d   = 1'b0;
		rev_d     = cfg.invert;
		lo_zero_d = 1'b0;
		if (below) begin
			if (cfg.pwm_cap[0]) begin
				up_code_d = LVL_DUTY;
			end else if (cfg.pwm_cap[1]) begin
				up_code_d = LVL_ACT;
				dn_code_d = LVL_DUTY;
				rev_d     = !cfg.invert;
			end else begin
				up_code_d = LVL_ACT;
			end
		end else if (above) begin
			if (cfg.pwm_cap[1]) begin
				dn_code_d = LVL_DUTY;
				sel51_d   = 1'b1;
			end else if (cfg.pwm_cap[0]) begin
				dn_code_d = LVL_ACT;
				up_code_d = LVL_DUTY;
				rev_d     = !cfg.invert;
				lo_zero_d = 1'b1;
			end else begin
				dn_code_d = LVL_ACT;
			end
		end
	end

	// Scaled error for the 25-step map.
	assign f25_prod = 28'(e_q) * 28'(F25_MULT);

	// Duty value, reversal and clamp, then the pin levels.
	always_comb begin
		five_e = {1'b0, e_q, 2'b00} + {3'b000, e_q};
		base   = sel51_q ? {1'b0, five_e} : f25_q;
		vsig   = rev_q ? (13'sd255 - $signed({1'b0, base})) : $signed({1'b0, base});
		lo     = lo_zero_q ? 8'd0 : cfg.min_duty;
		if (vsig < $signed({5'b00000, lo})) begin
			duty = lo;
		end else if (vsig > 13'sd255) begin
			duty = DUTY_FULL;
		end else begin
			duty = vsig[7:0];
		end
		act   = cfg.invert ? 8'd0 : DUTY_FULL;
		inact = cfg.invert ? DUTY_FULL : 8'd0;
		unique case (up_code_q)
			LVL_ACT:  up_lvl = act;
			LVL_DUTY: up_lvl = duty;
			default:  up_lvl = inact;
		endcase
		unique case (dn_code_q)
			LVL_ACT:  dn_lvl = act;
			LVL_DUTY: dn_lvl = duty;
			default:  dn_lvl = inact;
		endcase
	end

	// Move state: command latch, permit take and end of move.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_req_q <= 1'b0;
			in_prog_q  <= 1'b0;
			start_q    <= 32'd0;
			permit_q   <= PERMIT_W'(MOVE_QUOTA);
			target_q   <= 8'd0;
			off_q      <= 1'b0;
		end else if (cmd.accept) begin
			if (func == FUNC_CMD) begin
				move_req_q <= 1'b1;
				off_q      <= off_request;
				if (!off_request) begin
					target_q <= target_value;
				end
				if (start_q != 32'd0) begin
					start_q <= nonzero_time(now_ms);
				end
			end else if (status.poll_go && !in_prog_q) begin
				in_prog_q <= 1'b1;
				permit_q  <= permit_q - 1'b1;
			end
		end else if (cmd.fin) begin
			if (stop_q) begin
				start_q    <= 32'd0;
				move_req_q <= 1'b0;
				in_prog_q  <= 1'b0;
				if (permit_q != PERMIT_MAX) begin
					permit_q <= permit_q + 1'b1;
				end
			end else if (start_q == 32'd0) begin
				start_q <= nonzero_time(now_q);
			end
		end
	end

	// Payload, divider and evaluation registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= feedback_sample;
			now_q    <= now_ms;
			// Only the accepted flag is set in a command or short-path result.
			res_q    <= {19'd0, (func == FUNC_CMD)};
		end
		if (cmd.prep) begin
			rem_q     <= n_full[17:0];
			dsh_q     <= {d_abs, 7'b0};
			quo_q     <= 8'd0;
			neg_q     <= s_diff[11] ^ d_diff[11];
			sat_q     <= n_full >= {d_abs, 8'b0};
			timeout_q <= timeout_d;
		end
		if (cmd.div_step) begin
			rem_q <= rem_d;
			dsh_q <= dsh_d;
			quo_q <= quo_d;
		end
		if (cmd.eval) begin
			e_q       <= magn[7:0];
			stop_q    <= !below && !above;
			up_code_q <= up_code_d;
			dn_code_q <= dn_code_d;
			sel51_q   <= sel51_d;
			rev_q     <= rev_d;
			lo_zero_q <= lo_zero_d;
		end
		if (cmd.mul) begin
			f25_q <= f25_prod[F25_SHIFT+11:F25_SHIFT];
		end
		if (cmd.fin) begin
			res_q.drive_changed  <= 1'b1;
			res_q.up_drive       <= up_lvl;
			res_q.down_drive     <= dn_lvl;
			res_q.target_reached <= stop_q;
			res_q.timed_out      <= stop_q && timeout_q;
			res_q.accepted       <= 1'b0;
		end
		if (cmd.push) begin
			out_q <= res_q;
		end
	end

endmodule

### hw/rtl/motor_position_drive.sv
// ----------------------------------------------------------------------------
// Motor position drive
// Drives a two-pin motor toward a target position from position feedback.
// ----------------------------------------------------------------------------
// Usage: items enter on the in channel (in_valid/in_ready) and every item
// gives exactly one result on the out channel (out_valid/out_ready); each
// transfer completes when valid and ready are both high at a clock edge.
// Command items latch a target or an off request; fast polls move the motor
// and report the pin drives. Slow polls and idle polls return all zeros.
// Order: a command or a poll without motion work goes from its transfer
// straight to the delivery step and the output register; a poll that
// drives the motor first passes setup, the feedback divider (two quotient
// bits per cycle), evaluation, the duty multiply and the final update.
// A new item is taken only after the last has entered the output register,
// even while that result still waits. Reset: all move state clears, the
// permit counter loads MOVE_QUOTA and the registers take their defaults.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must write it only while the block is idle; the block does not enforce it.
// Stall: while out_ready is low the result holds in the output register;
// a following item runs up to its delivery step and waits there.
// ----------------------------------------------------------------------------
module motor_position_drive
	import mpd_pkg::*;
#(
	parameter int unsigned MOVE_QUOTA = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            func,
	input  logic [7:0]            target_value,
	input  logic                  off_request,
	input  logic [9:0]            feedback_sample,
	input  logic [31:0]           now_ms,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  drive_changed,
	output logic [7:0]            up_drive,
	output logic [7:0]            down_drive,
	output logic                  target_reached,
	output logic                  timed_out,
	output logic                  accepted
);

	cfg_t       cfg_q;
	ctrl_cmd_t  cmd;
	dp_status_t status;
	result_t    result;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fb_closed   <= FB_FULL;
			cfg_q.fb_open     <= 11'd0;
			cfg_q.max_on_time <= DEFAULT_ON_TIME;
			cfg_q.fb_present  <= 1'b0;
			cfg_q.invert      <= 1'b0;
			cfg_q.pwm_cap     <= 2'd0;
			cfg_q.tolerance   <= 8'd5;
			cfg_q.min_duty    <= 8'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FB_CLOSED:  cfg_q.fb_closed   <= cfg_data[10:0];
				REG_FB_OPEN:    cfg_q.fb_open     <= cfg_data[10:0];
				REG_MAX_ON:     cfg_q.max_on_time <= cfg_data[30:0];
				REG_FB_PRESENT: cfg_q.fb_present  <= cfg_data[0];
				REG_INVERT:     cfg_q.invert      <= cfg_data[0];
				REG_PWM_CAP:    cfg_q.pwm_cap     <= cfg_data[1:0];
				REG_TOLERANCE:  cfg_q.tolerance   <= cfg_data[7:0];
				REG_MIN_DUTY:   cfg_q.min_duty    <= cfg_data[7:0];
				default:        cfg_q.min_duty    <= cfg_q.min_duty;
			endcase
		end
	end

	mpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mpd_datapath #(
		.MOVE_QUOTA (MOVE_QUOTA)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.func            (func),
		.target_value    (target_value),
		.off_request     (off_request),
		.feedback_sample (feedback_sample),
		.now_ms          (now_ms),
		.cmd             (cmd),
		.status          (status),
		.result          (result)
	);

	// Result fields to ports.
	assign drive_changed  = result.drive_changed;
	assign up_drive       = result.up_drive;
	assign down_drive     = result.down_drive;
	assign target_reached = result.target_reached;
	assign timed_out      = result.timed_out;
	assign accepted       = result.accepted;

endmodule
